FILE: rtl/assert_macros.svh
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/roc_pkg.sv
// shared constants, types and codes for the roc auc scorer
package roc_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int SCORE_BITS  = 16;

    localparam int SCORE_IN_W  = 16;
    localparam int SCORE_W     = (SCORE_BITS < SCORE_IN_W) ? SCORE_BITS : SCORE_IN_W;
    localparam int ADDR_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int PN_W        = 2 * CNT_W;
    localparam int REM_W       = PN_W + 1;

    localparam int FRAC_BITS   = 16;
    localparam int AUC_W       = FRAC_BITS + 1;
    localparam int QUO_STEPS   = FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(QUO_STEPS + 1);
    localparam int AUC_ONE     = 1 << FRAC_BITS;

    localparam int PAIR_OUT_W  = 19;
    localparam int COUNT_OUT_W = 11;
    localparam int STATUS_W    = 2;
    localparam int PAIR_MAX    = (1 << PAIR_OUT_W) - 1;
    localparam int COUNT_MAX   = (1 << COUNT_OUT_W) - 1;

    localparam int PAYLOAD_W   = AUC_W + PAIR_OUT_W + 2 * COUNT_OUT_W + STATUS_W;
    localparam int M_DATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W       = M_DATA_W - PAYLOAD_W;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ABSENT   = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_en;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic scan_last;
        logic item_last;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/roc_ram.sv
// generic single write port ram with registered read
module roc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/roc_ctrl.sv
// controller state machine sequencing scan, store, multiply, divide and result
module roc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    input  roc_pkg::dp_stat_t   stat,
    output roc_pkg::ctrl_cmd_t  cmd
);

    roc_pkg::state_t state_reg;
    roc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= roc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            roc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.full) begin
                        state_next = s_tlast ? roc_pkg::ST_MUL : roc_pkg::ST_IDLE;
                    end else if (stat.cnt_zero) begin
                        state_next = roc_pkg::ST_WRITE;
                    end else begin
                        state_next = roc_pkg::ST_SCAN;
                    end
                end
            end
            roc_pkg::ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (stat.scan_last) begin
                    state_next = roc_pkg::ST_WRITE;
                end
            end
            roc_pkg::ST_WRITE: begin
                cmd.wr_en  = 1'b1;
                state_next = stat.item_last ? roc_pkg::ST_MUL : roc_pkg::ST_IDLE;
            end
            roc_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = roc_pkg::ST_INIT;
            end
            roc_pkg::ST_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = roc_pkg::ST_DIV;
            end
            roc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = roc_pkg::ST_OUT;
                end
            end
            roc_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = roc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = roc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/roc_datapath.sv
// datapath: item store, pair counting, auc divider and result register
`include "assert_macros.svh"

module roc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [roc_pkg::SCORE_IN_W-1:0] s_tdata,  // score
    input  logic                          s_tuser,  // label
    input  logic                          s_tlast,  // last_item
    input  roc_pkg::ctrl_cmd_t            cmd,
    output roc_pkg::dp_stat_t             stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [roc_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int SW = roc_pkg::SCORE_W;
    localparam int AW = roc_pkg::ADDR_W;
    localparam int CW = roc_pkg::CNT_W;
    localparam int PW = roc_pkg::PN_W;
    localparam int RW = roc_pkg::REM_W;
    localparam int QW = roc_pkg::AUC_W;
    localparam int TW = roc_pkg::STEP_W;

    logic [SW-1:0]  score_reg;
    logic           label_reg;
    logic           last_reg;
    logic [CW-1:0]  stored_cnt_reg;
    logic [CW-1:0]  pos_reg;
    logic [CW-1:0]  neg_reg;
    logic [PW-1:0]  pair_reg;
    logic           ovf_reg;
    logic [AW-1:0]  scan_addr_reg;
    logic           rd_valid_reg;
    logic [PW-1:0]  pn_reg;
    logic [RW-1:0]  rem_reg;
    logic [QW-1:0]  quo_reg;
    logic [TW-1:0]  div_cnt_reg;
    logic           m_tvalid_reg;
    logic [roc_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [SW:0]    rd_data;
    logic [SW-1:0]  rd_score;
    logic           rd_label;
    logic           hit;
    logic           q_bit;
    logic [RW-1:0]  rem_diff;
    logic [PW-1:0]  pair_cap;
    logic           absent;
    logic [QW-1:0]  auc_out;
    logic [roc_pkg::PAIR_OUT_W-1:0]  pair_out;
    logic [roc_pkg::COUNT_OUT_W-1:0] pos_out;
    logic [roc_pkg::COUNT_OUT_W-1:0] neg_out;
    roc_pkg::status_t                status_out;

    roc_ram #(
        .WIDTH (SW + 1),
        .DEPTH (roc_pkg::MAX_ITEMS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (stored_cnt_reg[AW-1:0]),
        .wdata ({label_reg, score_reg}),
        .raddr (scan_addr_reg),
        .rdata (rd_data)
    );

    assign rd_score = rd_data[SW-1:0];
    assign rd_label = rd_data[SW];

    // positive: stored negative at or above; negative: stored positive strictly below
    assign hit = rd_valid_reg &&
                 (label_reg ? (!rd_label && (rd_score >= score_reg))
                            : (rd_label && (rd_score < score_reg)));

    assign q_bit    = rem_reg >= {1'b0, pn_reg};
    assign rem_diff = q_bit ? (rem_reg - {1'b0, pn_reg}) : rem_reg;
    assign pair_cap = (pair_reg > pn_reg) ? pn_reg : pair_reg;

    always_comb begin
        absent     = (pos_reg == '0) || (neg_reg == '0);
        auc_out    = '0;
        status_out = roc_pkg::STATUS_OK;
        if (absent) begin
            status_out = roc_pkg::STATUS_ABSENT;
        end else begin
            auc_out = (64'(quo_reg) > 64'(roc_pkg::AUC_ONE)) ?
                      QW'(roc_pkg::AUC_ONE) : quo_reg;
            if (ovf_reg) begin
                status_out = roc_pkg::STATUS_OVERFLOW;
            end
        end
        pair_out = (64'(pair_reg) > 64'(roc_pkg::PAIR_MAX)) ?
                   roc_pkg::PAIR_OUT_W'(roc_pkg::PAIR_MAX) : roc_pkg::PAIR_OUT_W'(pair_reg);
        pos_out  = (64'(pos_reg) > 64'(roc_pkg::COUNT_MAX)) ?
                   roc_pkg::COUNT_OUT_W'(roc_pkg::COUNT_MAX) : roc_pkg::COUNT_OUT_W'(pos_reg);
        neg_out  = (64'(neg_reg) > 64'(roc_pkg::COUNT_MAX)) ?
                   roc_pkg::COUNT_OUT_W'(roc_pkg::COUNT_MAX) : roc_pkg::COUNT_OUT_W'(neg_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_cnt_reg <= '0;
            pos_reg        <= '0;
            neg_reg        <= '0;
            pair_reg       <= '0;
            ovf_reg        <= 1'b0;
            scan_addr_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load) begin
                scan_addr_reg <= '0;
                if (stat.full) begin
                    ovf_reg <= 1'b1;
                end
            end else if (cmd.rd_en) begin
                scan_addr_reg <= scan_addr_reg + AW'(1);
            end
            if (hit) begin
                pair_reg <= pair_reg + PW'(1);
            end
            if (cmd.wr_en) begin
                stored_cnt_reg <= stored_cnt_reg + CW'(1);
                if (label_reg) begin
                    pos_reg <= pos_reg + CW'(1);
                end else begin
                    neg_reg <= neg_reg + CW'(1);
                end
            end
            if (cmd.div_init) begin
                div_cnt_reg <= TW'(roc_pkg::QUO_STEPS);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - TW'(1);
            end
            if (cmd.out_load) begin
                stored_cnt_reg <= '0;
                pos_reg        <= '0;
                neg_reg        <= '0;
                pair_reg       <= '0;
                ovf_reg        <= 1'b0;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            score_reg <= s_tdata[SW-1:0];
            label_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
        if (cmd.mul) begin
            pn_reg <= PW'(pos_reg) * PW'(neg_reg);
        end
        if (cmd.div_init) begin
            rem_reg <= RW'(pn_reg - pair_cap);
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= {rem_diff[RW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], q_bit};
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{roc_pkg::PAD_W{1'b0}}, status_out, neg_out, pos_out,
                            pair_out, auc_out};
        end
    end

    assign stat.full      = stored_cnt_reg == CW'(roc_pkg::MAX_ITEMS);
    assign stat.cnt_zero  = stored_cnt_reg == '0;
    assign stat.scan_last = CW'(scan_addr_reg) == (stored_cnt_reg - CW'(1));
    assign stat.item_last = last_reg;
    assign stat.div_done  = div_cnt_reg == TW'(1);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NEVER(a_no_write_full, aclk, aresetn, cmd.wr_en && stat.full, "store written while full")
    `ASSERT_CLKED(a_read_in_range, aclk, aresetn, cmd.rd_en |-> (CW'(scan_addr_reg) < stored_cnt_reg), "read beyond stored items")
    `ASSERT_CLKED(a_div_finished, aclk, aresetn, cmd.out_load |-> (div_cnt_reg == '0), "result loaded before divider finished")
    `ASSERT_CLKED(a_set_cleared, aclk, aresetn, cmd.out_load |=> (m_tvalid_reg && stored_cnt_reg == '0 && pair_reg == '0), "set not cleared after result")

endmodule

FILE: rtl/roc_auc_scorer.sv
// top level of the roc auc scorer: controller, datapath and result channel
//
// channel   direction  ports                                   payload
// s_        in         s_tvalid s_tready s_tdata s_tuser s_tlast score, label, last_item
// m_        out        m_tvalid m_tready m_tdata                auc, pairs, counts, status
//
// an item with n items already stored is accepted, then makes one store read per stored item
// through the single ram read port, then is written into the store; no new item is taken meanwhile.
// an item arriving with the store full is accepted and dropped.
// a last item then runs multiply, divider setup, 17 restoring divider steps and result load.
// reset clears all counters and the result valid flag; store contents need no clearing.
// a result held by m_tready low stalls the block only when the next result is ready.
module roc_auc_scorer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [roc_pkg::SCORE_IN_W-1:0] s_tdata,  // score[15:0]
    input  logic                           s_tuser,  // label
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [roc_pkg::M_DATA_W-1:0]   m_tdata   // auc_value, misordered_pairs,
                                                     // positive_count, negative_count,
                                                     // status, zero pad
);

    roc_pkg::ctrl_cmd_t cmd;
    roc_pkg::dp_stat_t  stat;

    roc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    roc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
